@@ rtl/aad_pkg.sv @@
// ----------------------------------------------------------------------------
// aad_pkg
// Shared types, constants and conversions for the area-average decimator.
// ----------------------------------------------------------------------------
package aad_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int RATIO_W     = 20;
	localparam int RAW_W       = 16;
	localparam int OUT_W       = 16;
	localparam int SMP_W       = 24;
	localparam int SUM_W       = 48;
	localparam int PROD_W      = SMP_W + RATIO_W;
	localparam int QUO_W       = SMP_W;
	localparam int REM_W       = RATIO_W;
	localparam int DIV_CNT_W   = $clog2(QUO_W + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W   = 2;

	// Unit weight and the reset ratio (2.0), both with FRAC_BITS fraction bits.
	localparam logic [RATIO_W-1:0] ONE_WEIGHT  = RATIO_W'(1 << FRAC_BITS);
	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(2 << FRAC_BITS);
	localparam logic [RAW_W-1:0]   MID_SAMPLE  = RAW_W'(1 << (RAW_W - 1));
	localparam logic [QUO_W-1:0]   MID_AVG     = QUO_W'(1) << (QUO_W - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATIO  = 2'd0,
		CFG_WIDE   = 2'd1,
		CFG_STEREO = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_AVG,
		KIND_COPY,
		KIND_MUTE
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DSTART,
		ST_DIV,
		ST_EMIT,
		ST_RMUL,
		ST_RSET
	} back_state_t;

	typedef struct packed {
		kind_t            kind;
		logic [SMP_W-1:0] xl;
		logic [SMP_W-1:0] xr;
		logic             last;
		logic             stereo;
	} entry_t;

	typedef struct packed {
		logic               go;
		logic [RATIO_W-1:0] ratio;
	} restart_t;

	typedef struct packed {
		logic               start;
		logic [SUM_W-1:0]   dvd_l;
		logic [SUM_W-1:0]   dvd_r;
		logic [RATIO_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo_l;
		logic [QUO_W-1:0] quo_r;
	} div_rsp_t;

	function automatic logic [SMP_W-1:0] to_offset24(input logic [RAW_W-1:0] raw,
			input logic wide);
		if (wide) begin
			return {raw ^ MID_SAMPLE, 8'd0};
		end
		return {raw[7:0], 16'd0};
	endfunction

	function automatic logic [OUT_W-1:0] to_out16(input logic [SMP_W-1:0] avg);
		return avg[SMP_W-1 -: OUT_W] ^ MID_SAMPLE;
	endfunction

endpackage

@@ rtl/aad_front.sv @@
// ----------------------------------------------------------------------------
// aad_front
// Converts incoming frames to offset binary and classifies them by mode.
// ----------------------------------------------------------------------------
module aad_front (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [aad_pkg::RAW_W-1:0]  left_raw,
	input  logic [aad_pkg::RAW_W-1:0]  right_raw,
	input  logic                       last_frame,
	input  logic [aad_pkg::RATIO_W-1:0] ratio,
	input  logic                       wide,
	input  logic                       stereo,
	input  logic                       q_full,
	output logic                       q_push,
	output aad_pkg::entry_t            q_data
);
	import aad_pkg::*;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_data.xl     = to_offset24(left_raw, wide);
		q_data.xr     = stereo ? to_offset24(right_raw, wide) : '0;
		q_data.last   = last_frame;
		q_data.stereo = stereo;
		// ratio of exactly one copies, below one mutes, otherwise average
		if (ratio == ONE_WEIGHT) begin
			q_data.kind = KIND_COPY;
		end else if (ratio < ONE_WEIGHT) begin
			q_data.kind = KIND_MUTE;
		end else begin
			q_data.kind = KIND_AVG;
		end
	end

endmodule

@@ rtl/aad_fifo.sv @@
// ----------------------------------------------------------------------------
// aad_fifo
// Short queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module aad_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  aad_pkg::entry_t wdata,
	input  logic            pop,
	output aad_pkg::entry_t rdata,
	output logic            full,
	output logic            empty
);
	import aad_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/aad_div.sv @@
// ----------------------------------------------------------------------------
// aad_div
// Two-lane restoring divider, one quotient bit per cycle, 24-bit saturated.
// ----------------------------------------------------------------------------
module aad_div (
	input  logic              clk,
	input  logic              arst_n,
	input  aad_pkg::div_req_t req,
	output aad_pkg::div_rsp_t rsp
);
	import aad_pkg::*;

	logic [REM_W-1:0]     rem_q  [2];
	logic [QUO_W-1:0]     dvd_q  [2];
	logic                 sat_q  [2];
	logic [RATIO_W-1:0]   div_q;
	logic                 zero_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;

	logic [SUM_W-1:0]     dvd_in [2];
	logic [REM_W:0]       part   [2];
	logic [REM_W:0]       diff   [2];
	logic                 ge     [2];
	logic [QUO_W-1:0]     quo    [2];

	assign dvd_in[0] = req.dvd_l;
	assign dvd_in[1] = req.dvd_r;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			part[i] = {rem_q[i], dvd_q[i][QUO_W-1]};
			ge[i]   = (part[i] >= {1'b0, div_q});
			diff[i] = part[i] - {1'b0, div_q};
			if (zero_q) begin
				quo[i] = MID_AVG;
			end else if (sat_q[i]) begin
				quo[i] = '1;
			end else begin
				quo[i] = dvd_q[i];
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.quo_l = quo[0];
	assign rsp.quo_r = quo[1];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			if (req.start) begin
				// quotient overflows 24 bits when the top half reaches the divisor
				sat_q[i] <= (dvd_in[i][SUM_W-1:QUO_W] >= (SUM_W - QUO_W)'(req.divisor));
				rem_q[i] <= dvd_in[i][QUO_W +: REM_W];
				dvd_q[i] <= dvd_in[i][QUO_W-1:0];
			end else if (cnt_q != '0) begin
				rem_q[i] <= ge[i] ? diff[i][REM_W-1:0] : part[i][REM_W-1:0];
				dvd_q[i] <= {dvd_q[i][QUO_W-2:0], ge[i]};
			end
		end
		if (req.start) begin
			div_q  <= req.divisor;
			zero_q <= (req.divisor == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				cnt_q <= DIV_CNT_W'(QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/aad_back.sv @@
// ----------------------------------------------------------------------------
// aad_back
// Accumulates weighted area per channel, divides and emits results.
// ----------------------------------------------------------------------------
module aad_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  aad_pkg::entry_t              q_data,
	output logic                         q_pop,
	input  logic [aad_pkg::RATIO_W-1:0]  ratio,
	input  aad_pkg::restart_t            restart,
	output aad_pkg::div_req_t            div_req,
	input  aad_pkg::div_rsp_t            div_rsp,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [aad_pkg::OUT_W-1:0] left_out,
	output logic signed [aad_pkg::OUT_W-1:0] right_out,
	output logic                         is_flush,
	output logic                         last_of_run
);
	import aad_pkg::*;

	back_state_t        state_q, state_d;
	entry_t             ent_q;
	logic [SUM_W-1:0]   sum_l_q, sum_r_q;
	logic [PROD_W-1:0]  prod_l_q, prod_r_q;
	logic [RATIO_W-1:0] weight_q;
	logic               flush_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   left_q, right_q;
	logic               is_flush_q, last_q;

	logic               bnd, out_free, emit, div_start;
	logic [RATIO_W-1:0] rest, mulw, used;
	logic [OUT_W-1:0]   res_l, res_r;

	assign bnd      = (weight_q < ONE_WEIGHT);
	assign rest     = ONE_WEIGHT - weight_q;
	assign mulw     = (state_q == ST_RMUL) ? rest : (bnd ? weight_q : ONE_WEIGHT);
	assign used     = (ratio > weight_q) ? ratio - weight_q : '0;
	assign out_free = !out_valid_q || !out_stall;

	assign div_req.start   = div_start;
	assign div_req.dvd_l   = sum_l_q;
	assign div_req.dvd_r   = sum_r_q;
	assign div_req.divisor = flush_q ? used : ratio;

	always_comb begin
		case (ent_q.kind)
			KIND_COPY: begin
				res_l = to_out16(ent_q.xl);
				res_r = to_out16(ent_q.xr);
			end
			KIND_AVG: begin
				res_l = to_out16(div_rsp.quo_l);
				res_r = to_out16(div_rsp.quo_r);
			end
			default: begin
				res_l = '0;
				res_r = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = (q_data.kind == KIND_AVG) ? ST_MUL : ST_EMIT;
				end
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = (bnd || ent_q.last) ? ST_DSTART : ST_IDLE;
			end
			ST_DSTART: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					if (ent_q.kind != KIND_AVG || flush_q) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_RMUL;
					end
				end
			end
			ST_RMUL: begin
				state_d = ST_RSET;
			end
			ST_RSET: begin
				state_d = ent_q.last ? ST_DSTART : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_data;
		end
		if (state_q == ST_MUL || state_q == ST_RMUL) begin
			prod_l_q <= ent_q.xl * mulw;
			prod_r_q <= ent_q.xr * mulw;
		end
		if (emit) begin
			left_q     <= res_l;
			right_q    <= ent_q.stereo ? res_r : '0;
			is_flush_q <= flush_q;
			last_q     <= (ent_q.kind != KIND_AVG) || flush_q || !ent_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_l_q  <= '0;
			sum_r_q  <= '0;
			weight_q <= RATIO_RESET;
			flush_q  <= 1'b0;
		end else if (restart.go) begin
			sum_l_q  <= '0;
			sum_r_q  <= '0;
			weight_q <= restart.ratio;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						flush_q <= 1'b0;
					end
				end
				ST_ADD: begin
					sum_l_q <= sum_l_q + SUM_W'(prod_l_q);
					sum_r_q <= sum_r_q + SUM_W'(prod_r_q);
					if (!bnd) begin
						weight_q <= weight_q - ONE_WEIGHT;
					end
					flush_q <= !bnd;
				end
				ST_EMIT: begin
					if (emit && flush_q) begin
						sum_l_q  <= '0;
						sum_r_q  <= '0;
						weight_q <= ratio;
					end
				end
				ST_RSET: begin
					sum_l_q  <= SUM_W'(prod_l_q);
					sum_r_q  <= SUM_W'(prod_r_q);
					weight_q <= (ratio >= rest) ? ratio - rest : '0;
					flush_q  <= ent_q.last;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_out    = left_q;
	assign right_out   = right_q;
	assign is_flush    = is_flush_q;
	assign last_of_run = last_q;

endmodule

@@ rtl/pcm_area_average_decimator.sv @@
// ----------------------------------------------------------------------------
// pcm_area_average_decimator
// Fractional-ratio box-filter decimator for stereo or mono PCM frames.
// ----------------------------------------------------------------------------
// Rate: the front takes a request in any cycle that the two-entry queue has
// room; the back works on one frame at a time. A frame that only adds to the
// running area passes through the multiply and add states; copy and mute
// frames go straight to the emit state. A frame that crosses an output
// boundary, and a final frame for its flush result, wait on the 24-step
// restoring divider, which handles both channels side by side and raises
// its done flag. Any stall on the output holds the back end longer. A
// result waits in the output register while the queue keeps filling.
//
// Operation: each frame is turned into 24-bit offset binary (8-bit unsigned
// or 16-bit signed input). Whole samples are weighted by one, a sample that
// straddles an output boundary is split between the two outputs, and each
// output is the gathered area divided by the ratio (Q16). On a last frame
// the remainder is divided by the weight actually gathered and flagged with
// is_flush, and the stream restarts. A ratio of exactly one copies frames
// through; a ratio below one gives zero results. Writing the ratio register
// restarts the stream. Configure only while the block is idle.
// ----------------------------------------------------------------------------
module pcm_area_average_decimator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [aad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aad_pkg::RATIO_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [aad_pkg::RAW_W-1:0]        left_raw,
	input  logic [aad_pkg::RAW_W-1:0]        right_raw,
	input  logic                             last_frame,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [aad_pkg::OUT_W-1:0] left_out,
	output logic signed [aad_pkg::OUT_W-1:0] right_out,
	output logic                             is_flush,
	output logic                             last_of_run
);
	import aad_pkg::*;

	// configuration registers
	logic [RATIO_W-1:0] ratio_q;
	logic               wide_q;
	logic               stereo_q;

	restart_t restart;
	entry_t   q_wdata, q_rdata;
	logic     q_push, q_pop, q_full, q_empty;
	div_req_t div_req;
	div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= RATIO_RESET;
			wide_q   <= 1'b1;
			stereo_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_RATIO:  ratio_q  <= cfg_data;
				CFG_WIDE:   wide_q   <= cfg_data[0];
				CFG_STEREO: stereo_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// a ratio write clears both sums and reloads the owed weight
	assign restart.go    = cfg_wr_en && (cfg_index == CFG_RATIO);
	assign restart.ratio = cfg_data;

	aad_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.left_raw   (left_raw),
		.right_raw  (right_raw),
		.last_frame (last_frame),
		.ratio      (ratio_q),
		.wide       (wide_q),
		.stereo     (stereo_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	aad_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	aad_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	aad_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.ratio       (ratio_q),
		.restart     (restart),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_out    (left_out),
		.right_out   (right_out),
		.is_flush    (is_flush),
		.last_of_run (last_of_run)
	);

endmodule

@@ rtl/aad_checker.sv @@
// ----------------------------------------------------------------------------
// aad_checker
// Port-level checks on the decimator's result stream.
// ----------------------------------------------------------------------------
module aad_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [aad_pkg::OUT_W-1:0] left_out,
	input logic signed [aad_pkg::OUT_W-1:0] right_out,
	input logic                             is_flush,
	input logic                             last_of_run
);

	// set after a result that is not the last of its run
	logic pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			pending_q <= !last_of_run;
		end
	end

	// the edge that sees reset low has cleared the result register by the next
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out)
			&& $stable(is_flush) && $stable(last_of_run))
		else $error("stalled result changed");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_flush |-> last_of_run)
		else $error("flush result not last of its run");

	a_run_ends_flush: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pending_q |-> is_flush && last_of_run)
		else $error("second result of a run is not a flush");

endmodule

bind pcm_area_average_decimator aad_checker u_aad_checker (.*);

@@ dv/aad_frame_scoreboard.sv @@
// ----------------------------------------------------------------------------
// aad_frame_scoreboard
// Watches the register port and both request channels of the area-average
// decimator, predicts every output sample and compares it field by field.
// ----------------------------------------------------------------------------
module aad_frame_scoreboard (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [aad_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aad_pkg::RATIO_W-1:0]   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [aad_pkg::RAW_W-1:0]     left_raw,
	input  logic [aad_pkg::RAW_W-1:0]     right_raw,
	input  logic                          last_frame,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [aad_pkg::OUT_W-1:0]     left_out,
	input  logic [aad_pkg::OUT_W-1:0]     right_out,
	input  logic                          is_flush,
	input  logic                          last_of_run,
	output int                            mismatches,
	output int                            owed_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import aad_pkg::*;

	localparam int          RATIO_CAP  = 16;
	localparam logic [63:0] UNIT_W     = 64'd1 << FRAC_BITS;
	localparam logic [63:0] AVG_CEIL   = 64'hFF_FFFF;
	localparam logic [19:0] COPY_RATIO = 20'h10000;

	typedef struct packed {
		logic [OUT_W-1:0] left;
		logic [OUT_W-1:0] right;
		logic             flush;
		logic             last;
	} pcm_result_t;

	logic [RATIO_W-1:0] ratio_reg;
	logic               wide_reg;
	logic               stereo_reg;
	logic [63:0]        area_l;
	logic [63:0]        area_r;
	logic [63:0]        owed_weight;
	pcm_result_t        owed_results[$];

	function automatic logic [63:0] ratio_fixed();
		logic [63:0] r;
		r = {44'd0, ratio_reg};
		if (FRAC_BITS >= 16) begin
			r = r << (FRAC_BITS - 16);
		end else begin
			r = r >> (16 - FRAC_BITS);
		end
		if (r > (64'(RATIO_CAP) << FRAC_BITS)) begin
			r = 64'(RATIO_CAP) << FRAC_BITS;
		end
		return r;
	endfunction

	function automatic logic [63:0] widen_sample(input logic [15:0] raw);
		if (wide_reg) begin
			return {40'd0, raw ^ 16'h8000, 8'd0};
		end
		return {40'd0, raw[7:0], 16'd0};
	endfunction

	function automatic logic [15:0] pack_average(input logic [63:0] avg);
		logic [63:0] a;
		a = (avg > AVG_CEIL) ? AVG_CEIL : avg;
		return a[23:8] ^ 16'h8000;
	endfunction

	function automatic logic [63:0] area_mean(input logic [63:0] area, input logic [63:0] weight);
		if (weight == 64'd0) begin
			return 64'h80_0000;
		end
		return area / weight;
	endfunction

	function automatic pcm_result_t make_result(input logic [15:0] l, input logic [15:0] r,
			input logic flush);
		pcm_result_t res;
		res.left  = l;
		res.right = stereo_reg ? r : 16'd0;
		res.flush = flush;
		res.last  = 1'b0;
		return res;
	endfunction

	task automatic restart_stream();
		area_l      = 64'd0;
		area_r      = 64'd0;
		owed_weight = ratio_fixed();
	endtask

	// Work out the output samples that one accepted frame gives.
	task automatic predict_frame(input logic [15:0] l, input logic [15:0] r, input logic last);
		logic [63:0] xl;
		logic [63:0] xr;
		logic [63:0] rat;
		logic [63:0] rest;
		logic [63:0] used;
		pcm_result_t runs[2];
		int          n;
		n   = 0;
		xl  = widen_sample(l);
		xr  = stereo_reg ? widen_sample(r) : 64'd0;
		rat = ratio_fixed();
		if (ratio_reg == COPY_RATIO) begin
			runs[0] = make_result(pack_average(xl), pack_average(xr), 1'b0);
			n = 1;
		end else if (rat < UNIT_W) begin
			runs[0] = make_result(16'd0, 16'd0, 1'b0);
			n = 1;
		end else begin
			if (owed_weight < UNIT_W) begin
				// straddling sample: close this output, carry the rest over
				rest = UNIT_W - owed_weight;
				area_l += xl * owed_weight;
				area_r += xr * owed_weight;
				runs[n] = make_result(pack_average(area_mean(area_l, rat)),
					pack_average(area_mean(area_r, rat)), 1'b0);
				n++;
				area_l = xl * rest;
				area_r = xr * rest;
				owed_weight = (rat >= rest) ? rat - rest : 64'd0;
			end else begin
				area_l += xl << FRAC_BITS;
				area_r += xr << FRAC_BITS;
				owed_weight -= UNIT_W;
			end
			if (last) begin
				used = (rat > owed_weight) ? rat - owed_weight : 64'd0;
				runs[n] = make_result(pack_average(area_mean(area_l, used)),
					pack_average(area_mean(area_r, used)), 1'b1);
				n++;
				restart_stream();
			end
		end
		runs[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) begin
			owed_results.push_back(runs[i]);
		end
	endtask

	task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s: expected %h, got %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pcm_result_t want;
		if (!arst_n) begin
			ratio_reg  = RATIO_RESET;
			wide_reg   = 1'b1;
			stereo_reg = 1'b1;
			restart_stream();
			owed_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_RATIO: begin
						ratio_reg = cfg_data;
						restart_stream();
					end
					CFG_WIDE:   wide_reg = cfg_data[0];
					CFG_STEREO: stereo_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_frame(left_raw, right_raw, last_frame);
			end
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					mismatches++;
					$display("%0t unexpected output: expected none, got %h %h %b %b",
						$time, left_out, right_out, is_flush, last_of_run);
				end else begin
					want = owed_results.pop_front();
					check_field("left_out", want.left, left_out);
					check_field("right_out", want.right, right_out);
					check_field("is_flush", {15'd0, want.flush}, {15'd0, is_flush});
					check_field("last_of_run", {15'd0, want.last}, {15'd0, last_of_run});
				end
			end
		end
		owed_count = owed_results.size();
	end

endmodule

@@ dv/tb_pcm_area_average_decimator.sv @@
// ----------------------------------------------------------------------------
// tb_pcm_area_average_decimator
// Drives PCM frame streams and register settings into the area-average
// decimator while a scoreboard alongside predicts and checks every sample.
// ----------------------------------------------------------------------------
module tb_pcm_area_average_decimator;
	timeunit 1ns;
	timeprecision 1ps;

	import aad_pkg::*;

	localparam int RANDOM_FRAMES = 1800;
	// back-end time for frames that give no output, with two queued
	localparam int SETTLE_CYCLES = 64;
	localparam int DRAIN_CYCLES  = 100;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [RATIO_W-1:0]   cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [RAW_W-1:0]     left_raw   = '0;
	logic [RAW_W-1:0]     right_raw  = '0;
	logic                 last_frame = 1'b0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic signed [OUT_W-1:0] left_out;
	logic signed [OUT_W-1:0] right_out;
	logic                 is_flush;
	logic                 last_of_run;

	int   mismatches;
	int   owed_count;
	int   frames_sent = 0;
	logic idling_on   = 1'b0;
	int   stall_hold  = 0;

	always #10 clk = ~clk;

	pcm_area_average_decimator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.left_raw    (left_raw),
		.right_raw   (right_raw),
		.last_frame  (last_frame),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_out    (left_out),
		.right_out   (right_out),
		.is_flush    (is_flush),
		.last_of_run (last_of_run)
	);

	aad_frame_scoreboard scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.left_raw    (left_raw),
		.right_raw   (right_raw),
		.last_frame  (last_frame),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_out    (left_out),
		.right_out   (right_out),
		.is_flush    (is_flush),
		.last_of_run (last_of_run),
		.mismatches  (mismatches),
		.owed_count  (owed_count)
	);

	// Idle length: mostly none or short, now and then a long hole.
	function automatic int pick_gap();
		int roll;
		if (!idling_on) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Sample values: mostly random over all 16 bits, sometimes the corners of
	// both formats (full scale, midscale, byte boundaries).
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 15))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h8000;
			3:       return 16'h7FFF;
			4:       return 16'h00FF;
			5:       return 16'hFF00;
			default: return 16'($urandom);
		endcase
	endfunction

	// Pick a ratio: copy, below one, the edges just above one and at the top,
	// and otherwise weighted towards small ratios so that outputs come often.
	function automatic logic [19:0] pick_ratio();
		case ($urandom_range(0, 19))
			0:       return 20'h10000;
			1:       return 20'($urandom_range(0, 20'h0FFFF));
			2:       return 20'h10001;
			3:       return 20'hFFFFF;
			4, 5, 6, 7, 8, 9:
				return 20'($urandom_range(20'h10001, 20'h20000));
			10, 11, 12, 13, 14, 15:
				return 20'($urandom_range(20'h20001, 20'h40000));
			default: return 20'($urandom_range(20'h40001, 20'hFFFFF));
		endcase
	endfunction

	// Output side: alternate free and stalled stretches while idling is on,
	// hold the stall low otherwise.
	always @(posedge clk) begin
		if (!idling_on) begin
			out_stall <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			out_stall <= ~out_stall;
			stall_hold = out_stall ? $urandom_range(0, 6) : pick_gap();
		end
	end

	// Offer one frame after a random gap and hold it until the block takes it.
	// Valid is only dropped when a gap follows, so it never toggles within a
	// single step.
	task automatic send_frame(input logic [15:0] l, input logic [15:0] r, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		left_raw   <= l;
		right_raw  <= r;
		last_frame <= last;
		do @(posedge clk); while (in_stall);
		frames_sent++;
	endtask

	// A well-formed stream closes with a last frame; a noisy one scatters
	// last flags at random and may leave the stream open.
	task automatic send_stream(input int len, input bit noisy);
		logic last;
		for (int i = 0; i < len; i++) begin
			last = noisy ? ($urandom_range(0, 3) == 0) : (i == len - 1);
			send_frame(pick_sample(), pick_sample(), last);
		end
	endtask

	// Drop valid, wait until every predicted sample has come out, then let
	// frames that produce nothing drain from the back end.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the selected registers on consecutive edges, then release the port.
	task automatic configure(input logic [2:0] which, input logic [19:0] ratio,
			input logic [19:0] wide_word, input logic [19:0] stereo_word);
		if (which[0]) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_RATIO;
			cfg_data  <= ratio;
			@(posedge clk);
		end
		if (which[1]) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_WIDE;
			cfg_data  <= wide_word;
			@(posedge clk);
		end
		if (which[2]) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_STEREO;
			cfg_data  <= stereo_word;
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int   target;
		int   streams;
		bit   noisy;
		logic [2:0] which;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings (ratio two, 16-bit, stereo), no idling. Positive and negative
		// full-scale samples; the third frame closes an output, the fourth
		// flushes; the last frame of the second stream gives both a boundary
		// output and a flush.
		send_frame(16'h7FFF, 16'h7FFF, 1'b0);
		send_frame(16'h7FFF, 16'h7FFF, 1'b0);
		send_frame(16'h8000, 16'h8000, 1'b0);
		send_frame(16'h8000, 16'h8000, 1'b1);
		send_frame(16'hFFFF, 16'h0000, 1'b0);
		send_frame(16'h0001, 16'hFFFE, 1'b0);
		send_frame(16'h5A5A, 16'hA5A5, 1'b1);

		// Ratio one and a half, 8-bit mono: upper bytes must be ignored, and the
		// stream is left open so that the next ratio write has to restart it.
		settle();
		idling_on <= 1'b1;
		configure(3'b111, 20'h18000, 20'h0, 20'h0);
		send_frame(16'hFFFF, 16'h1234, 1'b0);
		send_frame(16'h0000, 16'hFFFF, 1'b0);
		send_frame(16'h00FF, 16'h0F0F, 1'b0);
		send_frame(16'hFF00, 16'hF0F0, 1'b1);
		send_frame(16'h0080, 16'h0000, 1'b0);
		send_frame(16'h007F, 16'h0000, 1'b0);

		// Copy mode: last flag has no effect.
		settle();
		configure(3'b111, 20'h10000, 20'h1, 20'h1);
		send_frame(16'h0000, 16'hFFFF, 1'b1);
		send_frame(16'h8000, 16'h7FFF, 1'b0);
		send_frame(16'h7FFF, 16'h8000, 1'b0);

		// Ratio below one: muted outputs, just under one and zero.
		settle();
		configure(3'b001, 20'h0FFFF, 20'h0, 20'h0);
		send_frame(16'h1234, 16'h4321, 1'b1);
		send_frame(16'hFFFF, 16'hFFFF, 1'b0);
		settle();
		configure(3'b001, 20'h00000, 20'h0, 20'h0);
		send_frame(16'h0000, 16'h0000, 1'b0);

		// Smallest ratio above one, then the largest ratio.
		settle();
		configure(3'b001, 20'h10001, 20'h0, 20'h0);
		send_frame(16'h7FFF, 16'h8000, 1'b0);
		send_frame(16'h0000, 16'h0000, 1'b0);
		send_frame(16'hFFFF, 16'h0001, 1'b1);
		settle();
		configure(3'b001, 20'hFFFFF, 20'h0, 20'h0);
		send_frame(16'h7FFF, 16'h7FFF, 1'b0);
		send_frame(16'h8000, 16'h8000, 1'b0);
		send_frame(16'hFFFF, 16'h0000, 1'b1);

		// Random phases: each one retunes some registers while idle, then runs
		// mostly well-formed streams with a sprinkling of noisy ones. Skipping
		// the ratio write lets an open stream carry across a format change.
		target = frames_sent + RANDOM_FRAMES;
		which  = 3'b111;
		while (frames_sent < target) begin
			settle();
			idling_on <= ($urandom_range(0, 3) != 0);
			configure(which, pick_ratio(), 20'($urandom_range(0, 20'hFFFFF)),
				20'($urandom_range(0, 20'hFFFFF)));
			which = {$urandom_range(0, 1) == 0, $urandom_range(0, 1) == 0,
				$urandom_range(0, 3) != 0};
			streams = $urandom_range(1, 6);
			for (int s = 0; s < streams; s++) begin
				noisy = ($urandom_range(0, 7) == 0);
				send_stream(noisy ? $urandom_range(1, 8) : $urandom_range(1, 40), noisy);
			end
		end

		// Drain everything still owed, give the back end time to show any
		// stray output, then call the verdict.
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
